>>> rtl/shadow_return_stack_checker_top_macros.svh
// Assertion macros for the shadow return stack checker
`ifndef SHADOW_RETURN_STACK_CHECKER_TOP_MACROS_SVH
`define SHADOW_RETURN_STACK_CHECKER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// next-cycle implication, disabled in reset
`define SRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

>>> rtl/srsc_pkg.sv
// Package of types, codes and defaults for the shadow return stack checker
package srsc_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int SITE_BITS_DEF   = 48;

    localparam int SITE_W  = 48;
    localparam int INDEX_W = 16;
    localparam int CTX_W   = 32;
    localparam int CONT_W  = INDEX_W + 1;
    localparam int DOUT_W  = 9;

    localparam logic [1:0] OP_STAGE  = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_VERIFY = 2'd3;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_VERIFIED  = 2'd1;
    localparam logic [1:0] ST_SITE_MISS = 2'd2;
    localparam logic [1:0] ST_IDX_MISS  = 2'd3;

    localparam logic [2:0] FLT_NONE     = 3'd0;
    localparam logic [2:0] FLT_OVERFLOW = 3'd1;
    localparam logic [2:0] FLT_UNDER    = 3'd2;
    localparam logic [2:0] FLT_UNSTAGED = 3'd3;
    localparam logic [2:0] FLT_DSTAGE   = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [SITE_W-1:0]  site_address;
        logic [INDEX_W-1:0] call_index;
        logic [CTX_W-1:0]   context_id;
    } t_in_beat;

    typedef struct packed {
        logic [CTX_W-1:0]  live_context;
        logic [1:0]        verify_status;
        logic [CTX_W-1:0]  returned_from_context;
        logic [2:0]        fault;
        logic [DOUT_W-1:0] stack_depth_out;
    } t_out_beat;

endpackage

>>> rtl/srsc_frame_mem.sv
// Frame memory: one write port, one registered read port
module srsc_frame_mem #(
    parameter int DEPTH = srsc_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = srsc_pkg::SITE_BITS_DEF + srsc_pkg::CONT_W + srsc_pkg::CTX_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> rtl/shadow_return_stack_checker_top.sv
// Top level of the shadow return stack checker: control, state registers, result register
//
// Input channel: i_in_valid / o_in_stall carry one t_in_beat per beat (stage, push,
// pop or verify). Output channel: o_out_valid / i_out_stall carry exactly one
// t_out_beat per input beat, in order.
// Stage, push and verify beats, and a pop on an empty stack, finish in the cycle
// they are accepted; the result appears on the output in the next cycle. Any other
// pop reads its frame through the frame memory's registered read port and waits in
// S_POP, holding o_in_stall, until the result register is free, then loads its result.
// Throughput: one beat per cycle for stage, push and verify while the output does not
// stall; a pop takes no new beat until its frame is read and its result is loaded.
// The single result register decouples the sides: a new beat is taken while a
// result waits, provided that result is taken in the same cycle.
// While i_out_stall is high the result is held and, once the register is full,
// o_in_stall rises until the result moves on.
// Reset (synchronous, i_rst_n low) empties the stack, clears the current and
// staged contexts and any armed check; the frame memory is not cleared and needs
// no clearing pass.
module shadow_return_stack_checker_top #(
    parameter int STACK_DEPTH = srsc_pkg::STACK_DEPTH_DEF,
    parameter int SITE_BITS   = srsc_pkg::SITE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  srsc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output srsc_pkg::t_out_beat o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int SW = (SITE_BITS < srsc_pkg::SITE_W) ? SITE_BITS : srsc_pkg::SITE_W;
    localparam int CW = srsc_pkg::CONT_W;
    localparam int XW = srsc_pkg::CTX_W;
    localparam int FW = SW + CW + XW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [DW-1:0]       r_depth, n_depth;
    logic [XW-1:0]       r_active, n_active;
    logic [XW-1:0]       r_staged_id, n_staged_id;
    logic                r_staged_valid, n_staged_valid;
    logic                r_pending, n_pending;
    logic [SW-1:0]       r_pop_site, n_pop_site;
    logic [CW-1:0]       r_pop_cont, n_pop_cont;
    logic [XW-1:0]       r_left, n_left;
    logic                r_out_valid, n_out_valid;
    srsc_pkg::t_out_beat r_out, n_out;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_load;
    logic [1:0]    w_status;
    logic [2:0]    w_fault;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [DW-1:0] w_depth_m1;
    logic [FW-1:0] w_wr_data;
    logic [FW-1:0] w_rd_data;
    logic [SW-1:0] w_in_site;
    logic [DW+srsc_pkg::DOUT_W-1:0] w_depth_ext;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_depth_m1 = r_depth - DW'(1);
    assign w_in_site  = i_in_data.site_address[SW-1:0];
    assign w_wr_data  = {w_in_site, CW'(i_in_data.call_index) + CW'(1), r_active};

    srsc_frame_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (FW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_depth[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_depth_m1[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_depth        = r_depth;
        n_active       = r_active;
        n_staged_id    = r_staged_id;
        n_staged_valid = r_staged_valid;
        n_pending      = r_pending;
        n_pop_site     = r_pop_site;
        n_pop_cont     = r_pop_cont;
        n_left         = r_left;
        w_status       = srsc_pkg::ST_NONE;
        w_fault        = srsc_pkg::FLT_NONE;
        w_wr_en        = 1'b0;
        w_rd_en        = 1'b0;
        w_load         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_load = 1'b1;
                    unique case (i_in_data.op)
                        srsc_pkg::OP_STAGE: begin
                            if (r_staged_valid) begin
                                w_fault = srsc_pkg::FLT_DSTAGE;
                            end else begin
                                n_staged_id    = i_in_data.context_id;
                                n_staged_valid = 1'b1;
                            end
                        end
                        srsc_pkg::OP_PUSH: begin
                            if (!r_staged_valid) begin
                                w_fault = srsc_pkg::FLT_UNSTAGED;
                            end else if (r_depth == DW'(STACK_DEPTH)) begin
                                w_fault = srsc_pkg::FLT_OVERFLOW;
                            end else begin
                                w_wr_en        = 1'b1;
                                n_depth        = r_depth + DW'(1);
                                n_active       = r_staged_id;
                                n_staged_valid = 1'b0;
                            end
                        end
                        srsc_pkg::OP_POP: begin
                            if (r_depth == '0) begin
                                w_fault = srsc_pkg::FLT_UNDER;
                            end else begin
                                w_rd_en = 1'b1;
                                w_load  = 1'b0;
                                n_state = S_POP;
                            end
                        end
                        srsc_pkg::OP_VERIFY: begin
                            if (r_pending) begin
                                n_pending = 1'b0;
                                if (r_pop_site != w_in_site) begin
                                    w_status = srsc_pkg::ST_SITE_MISS;
                                end else if (r_pop_cont != CW'(i_in_data.call_index)) begin
                                    w_status = srsc_pkg::ST_IDX_MISS;
                                end else begin
                                    w_status = srsc_pkg::ST_VERIFIED;
                                end
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_depth    = w_depth_m1;
                    n_pop_site = w_rd_data[FW-1 -: SW];
                    n_pop_cont = w_rd_data[XW +: CW];
                    n_left     = r_active;
                    n_active   = w_rd_data[XW-1:0];
                    n_pending  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_depth_ext = {{srsc_pkg::DOUT_W{1'b0}}, n_depth};

    always_comb begin
        n_out_valid = w_load || (r_out_valid && i_out_stall);
        n_out       = r_out;
        if (w_load) begin
            n_out.live_context          = n_active;
            n_out.verify_status         = w_status;
            n_out.returned_from_context = n_left;
            n_out.fault                 = w_fault;
            n_out.stack_depth_out       = w_depth_ext[srsc_pkg::DOUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_depth        <= '0;
            r_active       <= '0;
            r_staged_id    <= '0;
            r_staged_valid <= 1'b0;
            r_pending      <= 1'b0;
            r_pop_site     <= '0;
            r_pop_cont     <= '0;
            r_left         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_depth        <= n_depth;
            r_active       <= n_active;
            r_staged_id    <= n_staged_id;
            r_staged_valid <= n_staged_valid;
            r_pending      <= n_pending;
            r_pop_site     <= n_pop_site;
            r_pop_cont     <= n_pop_cont;
            r_left         <= n_left;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "shadow_return_stack_checker_top_macros.svh"

    `SRSC_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n,
        w_in_acc && (i_in_data.op == srsc_pkg::OP_POP) && (r_depth != '0),
        r_state == S_POP)
    `SRSC_ASSERT_NOW(a_pop_stalls, i_clk, i_rst_n, r_state == S_POP, o_in_stall)
    `SRSC_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_wr_en, r_depth == $past(r_depth) + DW'(1))
    `SRSC_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(STACK_DEPTH))

endmodule

>>> dv/tb_shadow_return_stack_checker_top.sv
// Self-checking testbench for the shadow return stack checker: queued stimulus, predictor, scoreboard
module tb_shadow_return_stack_checker_top;
    import srsc_pkg::*;

    localparam int STACK_N     = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 20;
    localparam int CALM_TAIL   = 120;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    shadow_return_stack_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted checker state
    logic [SITE_W-1:0]  frm_site [STACK_N];
    logic [CONT_W-1:0]  frm_cont [STACK_N];
    logic [CTX_W-1:0]   frm_ctx  [STACK_N];
    int                 depth     = 0;
    logic [CTX_W-1:0]   cur_ctx   = '0;
    logic [CTX_W-1:0]   stg_ctx   = '0;
    logic               stg_ok    = 1'b0;
    logic               chk_armed = 1'b0;
    logic [SITE_W-1:0]  pop_site  = '0;
    logic [CONT_W-1:0]  pop_cont  = '0;
    logic [CTX_W-1:0]   left_ctx  = '0;

    // stimulus planning view of the stack
    logic [SITE_W-1:0]  plan_sites [$];
    logic [CONT_W-1:0]  plan_conts [$];
    logic               plan_staged = 1'b0;
    logic [SITE_W-1:0]  plan_site   = '0;
    logic [CONT_W-1:0]  plan_cont   = '0;

    t_in_beat  pend_q [$];
    t_out_beat due_reports_q [$];

    int n_planned = 0;
    int beats_in  = 0;
    int n_results = 0;
    int n_errs    = 0;
    int cyc_cnt   = 0;
    int src_gap   = 0;
    int sink_gap  = 0;
    int st_seen  [4];
    int flt_seen [5];
    bit in_taken  = 1'b0;

    function automatic t_out_beat track_call_stack(input t_in_beat b);
        t_out_beat r;
        r = '0;
        case (b.op)
            OP_STAGE: begin
                if (stg_ok) begin
                    r.fault = FLT_DSTAGE;
                end else begin
                    stg_ctx = b.context_id;
                    stg_ok  = 1'b1;
                end
            end
            OP_PUSH: begin
                if (!stg_ok) begin
                    r.fault = FLT_UNSTAGED;
                end else if (depth >= STACK_N) begin
                    r.fault = FLT_OVERFLOW;
                end else begin
                    frm_site[depth] = b.site_address;
                    frm_cont[depth] = {1'b0, b.call_index} + 17'd1;
                    frm_ctx[depth]  = cur_ctx;
                    depth++;
                    cur_ctx = stg_ctx;
                    stg_ok  = 1'b0;
                end
            end
            OP_POP: begin
                if (depth == 0) begin
                    r.fault = FLT_UNDER;
                end else begin
                    depth--;
                    pop_site  = frm_site[depth];
                    pop_cont  = frm_cont[depth];
                    left_ctx  = cur_ctx;
                    cur_ctx   = frm_ctx[depth];
                    chk_armed = 1'b1;
                end
            end
            OP_VERIFY: begin
                if (chk_armed) begin
                    chk_armed = 1'b0;
                    if (pop_site != b.site_address)
                        r.verify_status = ST_SITE_MISS;
                    else if (pop_cont != {1'b0, b.call_index})
                        r.verify_status = ST_IDX_MISS;
                    else
                        r.verify_status = ST_VERIFIED;
                end
            end
        endcase
        r.live_context          = cur_ctx;
        r.returned_from_context = left_ctx;
        r.stack_depth_out       = DOUT_W'(depth);
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            n_errs++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin : mon
        t_out_beat want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (due_reports_q.size() == 0) begin
                n_errs++;
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, o_out_data);
            end else begin
                want = due_reports_q.pop_front();
                st_seen[want.verify_status]++;
                if (want.fault <= FLT_DSTAGE)
                    flt_seen[want.fault]++;
                cmp_field("live_context", want.live_context, o_out_data.live_context);
                cmp_field("verify_status", 32'(want.verify_status),
                          32'(o_out_data.verify_status));
                cmp_field("returned_from_context", want.returned_from_context,
                          o_out_data.returned_from_context);
                cmp_field("fault", 32'(want.fault), 32'(o_out_data.fault));
                cmp_field("stack_depth_out", 32'(want.stack_depth_out),
                          32'(o_out_data.stack_depth_out));
            end
        end
        if (in_taken) begin
            due_reports_q.push_back(track_call_stack(i_in_data));
            beats_in++;
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cyc_cnt, due_reports_q.size());
            $display("tb_shadow_return_stack_checker_top: FAIL");
            $finish;
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge i_clk) begin : drv
        bit calm;
        if (i_rst_n) begin
            calm = (pend_q.size() < CALM_TAIL) || ((beats_in / 64) % 4 == 3);
            if (!i_in_valid || in_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                    src_gap = $urandom_range(0, 3);
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    i_in_data  <= pend_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                sink_gap = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [SITE_W-1:0] rand_site();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return w[SITE_W-1:0];
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return INDEX_W'($urandom);
        endcase
    endfunction

    task automatic queue_beat(input logic [1:0] op, input logic [SITE_W-1:0] site,
                              input logic [INDEX_W-1:0] idx, input logic [CTX_W-1:0] ctx);
        t_in_beat b;
        b.op           = op;
        b.site_address = site;
        b.call_index   = idx;
        b.context_id   = ctx;
        pend_q.push_back(b);
        n_planned++;
        case (op)
            OP_STAGE: plan_staged = 1'b1;
            OP_PUSH: begin
                if (plan_staged && plan_sites.size() < STACK_N) begin
                    plan_sites.push_back(site);
                    plan_conts.push_back({1'b0, idx} + 17'd1);
                    plan_staged = 1'b0;
                end
            end
            OP_POP: begin
                if (plan_sites.size() != 0) begin
                    plan_site = plan_sites.pop_back();
                    plan_cont = plan_conts.pop_back();
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_call();
        if (!plan_staged)
            queue_beat(OP_STAGE, rand_site(), rand_index(), $urandom);
        queue_beat(OP_PUSH, rand_site(), rand_index(), $urandom);
    endtask

    // pop, optionally a nested call, then the return-site check
    task automatic queue_return(input bit nest);
        logic [SITE_W-1:0]  s;
        logic [INDEX_W-1:0] x;
        int                 k;
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        if (nest)
            queue_call();
        s = plan_site;
        x = plan_cont[INDEX_W-1:0];
        k = $urandom_range(0, 9);
        if (k == 7)
            s[$urandom_range(0, SITE_W - 1)] ^= 1'b1;
        else if (k >= 8)
            x[$urandom_range(0, INDEX_W - 1)] ^= 1'b1;
        queue_beat(OP_VERIFY, s, x, $urandom);
    endtask

    task automatic queue_random(input int target);
        int r;
        while (n_planned < target) begin
            r = $urandom_range(0, 99);
            if (r < 40 && plan_sites.size() < 24)
                queue_call();
            else if (r < 75)
                queue_return(1'b0);
            else if (r < 85)
                queue_return(1'b1);
            else
                queue_beat(2'($urandom_range(0, 3)), rand_site(), rand_index(), $urandom);
        end
    endtask

    initial begin
        // directed corner cases
        queue_beat(OP_VERIFY, '1, '1, '1);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_PUSH, rand_site(), rand_index(), $urandom);
        queue_beat(OP_STAGE, rand_site(), rand_index(), 32'hFFFF_FFFF);
        queue_beat(OP_STAGE, rand_site(), rand_index(), 32'h1234_5678);
        queue_beat(OP_PUSH, '1, '1, $urandom);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_VERIFY, '1, '1, $urandom);
        queue_beat(OP_VERIFY, '1, '1, $urandom);
        queue_beat(OP_STAGE, rand_site(), rand_index(), '0);
        queue_beat(OP_PUSH, '0, '0, '1);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_VERIFY, 48'h1, 16'h5, $urandom);
        queue_beat(OP_STAGE, rand_site(), rand_index(), 32'hA5A5_0001);
        queue_beat(OP_PUSH, 48'h0000_1000_0001, 16'd7, $urandom);
        queue_beat(OP_STAGE, rand_site(), rand_index(), 32'h5A5A_0002);
        queue_beat(OP_PUSH, 48'h8000_2000_0002, 16'd9, $urandom);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_STAGE, rand_site(), rand_index(), 32'h0F0F_0003);
        queue_beat(OP_PUSH, 48'h4000_3000_0003, 16'd3, $urandom);
        queue_beat(OP_VERIFY, 48'h8000_2000_0002, 16'd10, $urandom);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_VERIFY, 48'h4000_3000_0003, 16'd4, $urandom);
        queue_beat(OP_POP, rand_site(), rand_index(), $urandom);
        queue_beat(OP_VERIFY, 48'h0000_1000_0001, 16'd8, $urandom);

        queue_random(140);

        // fill to the top, overflow, then keep working on a deep stack
        while (plan_sites.size() < STACK_N)
            queue_call();
        queue_call();
        queue_beat(OP_PUSH, rand_site(), rand_index(), $urandom);

        queue_random(760);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in != n_planned || due_reports_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d beats, %0d results: %0d verified, %0d site and %0d index misses",
                 beats_in, n_results, st_seen[ST_VERIFIED], st_seen[ST_SITE_MISS],
                 st_seen[ST_IDX_MISS]);
        $display("Faults: %0d overflow, %0d underflow, %0d unstaged push, %0d double stage",
                 flt_seen[FLT_OVERFLOW], flt_seen[FLT_UNDER], flt_seen[FLT_UNSTAGED],
                 flt_seen[FLT_DSTAGE]);
        if (n_errs == 0)
            $display("tb_shadow_return_stack_checker_top: PASS");
        else
            $display("tb_shadow_return_stack_checker_top: FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/srsc_pkg.sv
rtl/srsc_frame_mem.sv
rtl/shadow_return_stack_checker_top.sv
dv/tb_shadow_return_stack_checker_top.sv
